// ----- hw/rtl/csvg_pkg.sv -----
// curved screen vertex generator: shared constants, types and helper functions
// used by every module of the block, no dependencies
package csvg_pkg;

	localparam int MAX_SEGMENTS    = 64;
	localparam int CORDIC_STEPS    = 20;
	localparam int IDX_W           = $clog2(MAX_SEGMENTS + 1);
	localparam int TAB_DEPTH       = MAX_SEGMENTS + 1;
	localparam int WIDE_W          = 16;
	localparam int STEPS_PER_STAGE = 2;
	localparam int CORDIC_STAGES   = (CORDIC_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	localparam int CORDIC_W        = 34;
	localparam int DIV_W           = 48;
	localparam int DEN_W           = 32;
	localparam int CNT_W           = $clog2(DIV_W + 1);

	localparam logic [24:0] MIN_CURV        = 25'd1;
	localparam logic [24:0] MAX_CURV        = 25'd23592960;
	localparam logic [30:0] RAD_MAX         = 31'h7FFF_FFFF;
	localparam logic [28:0] INV4PI_Q32      = 29'd341782638;
	localparam logic [21:0] DEG_PER_RAD_Q16 = 22'd3754936;
	localparam logic [31:0] GAIN_Q30        = 32'd652032875;
	localparam logic [9:0]  ARC_DIV         = 10'd720;

	typedef enum logic [2:0] {
		REG_WIDTH    = 3'd0,
		REG_HEIGHT   = 3'd1,
		REG_DISTANCE = 3'd2,
		REG_CURV     = 3'd3,
		REG_FIXED    = 3'd4,
		REG_VERTICAL = 3'd5,
		REG_SEGMENTS = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [23:0]      width;
		logic [23:0]      height;
		logic [23:0]      vdist;
		logic [24:0]      curv;
		logic             fixed;
		logic             vertical;
		logic [IDX_W-1:0] nseg;
	} cfg_t;

	typedef struct packed {
		logic [16:0] tex;
		logic [7:0]  first_slot;
		logic [7:0]  second_slot;
		logic        has_quad;
		logic [7:0]  next_first;
		logic [7:0]  next_second;
		logic [8:0]  tri_offset;
	} side_t;

	typedef struct packed {
		logic [31:0] turn;
		logic [16:0] tex;
	} tab_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		tab_t             data;
	} tab_wr_t;

	// arctan(2^-k) in binary angle units, 2^32 per turn
	function automatic logic [31:0] atan_turn(input int k);
		logic [31:0] v;
		case (k)
			0:  v = 32'd536870912;
			1:  v = 32'd316933406;
			2:  v = 32'd167458907;
			3:  v = 32'd85004756;
			4:  v = 32'd42667331;
			5:  v = 32'd21354465;
			6:  v = 32'd10679838;
			7:  v = 32'd5340245;
			8:  v = 32'd2670163;
			9:  v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			24: v = 32'd41;
			25: v = 32'd20;
			26: v = 32'd10;
			27: v = 32'd5;
			28: v = 32'd3;
			29: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/csvg_div.sv -----
// bit-serial rounding divider, one quotient bit per cycle
// depends on csvg_pkg
module csvg_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [csvg_pkg::DIV_W-1:0]  num,
	input  logic [csvg_pkg::DEN_W-1:0]  den,
	output logic                        done,
	output logic [csvg_pkg::DIV_W-1:0]  quot
);

	logic                       run_q;
	logic                       done_q;
	logic [csvg_pkg::CNT_W-1:0] cnt_q;
	logic [csvg_pkg::DEN_W-1:0] r_q;
	logic [csvg_pkg::DEN_W-1:0] d_q;
	logic [csvg_pkg::DIV_W-1:0] q_q;
	logic [csvg_pkg::DEN_W:0]   trial;
	logic                       ge;

	always_comb begin
		trial = {r_q, q_q[csvg_pkg::DIV_W-1]};
		ge    = trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= csvg_pkg::CNT_W'(csvg_pkg::DIV_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - csvg_pkg::CNT_W'(1);
				if (cnt_q == csvg_pkg::CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// half the divisor is added up front for round to nearest
	always_ff @(posedge clk) begin
		if (start) begin
			d_q <= den;
			r_q <= '0;
			q_q <= num + csvg_pkg::DIV_W'(den >> 1);
		end else if (run_q) begin
			r_q <= ge ? csvg_pkg::DEN_W'(trial - {1'b0, d_q}) : trial[csvg_pkg::DEN_W-1:0];
			q_q <= {q_q[csvg_pkg::DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

// ----- hw/rtl/csvg_prep.sv -----
// table builder: radius and per-index binary angle and texture coordinate
// depends on csvg_pkg and csvg_div
module csvg_prep (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  csvg_pkg::cfg_t            cfg,
	output logic                      busy,
	output logic [30:0]               rad,
	output csvg_pkg::tab_wr_t         tab_wr
);

	typedef enum logic [8:0] {
		P_IDLE   = 9'b000000001,
		P_RAD    = 9'b000000010,
		P_RAD_W  = 9'b000000100,
		P_TURN   = 9'b000001000,
		P_TURN_W = 9'b000010000,
		P_MUL    = 9'b000100000,
		P_TEX    = 9'b001000000,
		P_TEX_W  = 9'b010000000,
		P_WRITE  = 9'b100000000
	} prep_state_t;

	prep_state_t                  state_q;
	logic [csvg_pkg::IDX_W-1:0]   i_q;
	logic [30:0]                  rad_q;
	logic [31:0]                  turn_q;
	logic [16:0]                  tex_q;
	logic [csvg_pkg::DIV_W-1:0]   mr_q;
	logic [28:0]                  mk_q;
	logic [csvg_pkg::DIV_W-1:0]   acc_q;

	logic [23:0]                  len;
	logic [24:0]                  deg;
	logic [csvg_pkg::IDX_W:0]     two_i;
	logic [csvg_pkg::IDX_W:0]     nn;
	logic [csvg_pkg::IDX_W:0]     mag;
	logic                         neg;
	logic                         div_start;
	logic                         div_done;
	logic [csvg_pkg::DIV_W-1:0]   div_num;
	logic [csvg_pkg::DEN_W-1:0]   div_den;
	logic [csvg_pkg::DIV_W-1:0]   div_quot;

	always_comb begin
		len   = cfg.vertical ? cfg.height : cfg.width;
		if (cfg.curv < csvg_pkg::MIN_CURV) begin
			deg = csvg_pkg::MIN_CURV;
		end else if (cfg.curv > csvg_pkg::MAX_CURV) begin
			deg = csvg_pkg::MAX_CURV;
		end else begin
			deg = cfg.curv;
		end
		two_i = {i_q, 1'b0};
		nn    = {1'b0, cfg.nseg};
		neg   = two_i < nn;
		mag   = neg ? (nn - two_i) : (two_i - nn);
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = csvg_pkg::DEN_W'(1);
		unique case (state_q)
			P_RAD: begin
				div_start = 1'b1;
				div_num   = csvg_pkg::DIV_W'(len) * csvg_pkg::DIV_W'(csvg_pkg::DEG_PER_RAD_Q16);
				div_den   = csvg_pkg::DEN_W'(deg);
			end
			P_TURN: begin
				div_start = 1'b1;
				if (cfg.fixed) begin
					div_num = (csvg_pkg::DIV_W'(mag) * csvg_pkg::DIV_W'(deg)) << 16;
					div_den = csvg_pkg::DEN_W'(csvg_pkg::DEN_W'(csvg_pkg::ARC_DIV)
						* csvg_pkg::DEN_W'(cfg.nseg));
				end else begin
					div_num = (csvg_pkg::DIV_W'(mag) * csvg_pkg::DIV_W'(len)) << 16;
					div_den = csvg_pkg::DEN_W'(csvg_pkg::DEN_W'(cfg.nseg)
						* csvg_pkg::DEN_W'(rad_q));
				end
			end
			P_TEX: begin
				div_start = 1'b1;
				div_num   = csvg_pkg::DIV_W'(i_q) << 16;
				div_den   = csvg_pkg::DEN_W'(cfg.nseg);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	csvg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			i_q     <= '0;
		end else begin
			unique case (state_q)
				P_IDLE: begin
					if (start) begin
						i_q     <= '0;
						state_q <= cfg.fixed ? P_RAD : P_TURN;
					end
				end
				P_RAD:    state_q <= P_RAD_W;
				P_RAD_W:  if (div_done) state_q <= P_TURN;
				P_TURN:   state_q <= P_TURN_W;
				P_TURN_W: if (div_done) state_q <= cfg.fixed ? P_TEX : P_MUL;
				P_MUL:    if (mk_q == '0) state_q <= P_TEX;
				P_TEX:    state_q <= P_TEX_W;
				P_TEX_W:  if (div_done) state_q <= P_WRITE;
				P_WRITE: begin
					if (i_q == cfg.nseg) begin
						state_q <= P_IDLE;
					end else begin
						i_q     <= i_q + csvg_pkg::IDX_W'(1);
						state_q <= P_TURN;
					end
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == P_IDLE && start && !cfg.fixed) begin
			rad_q <= (cfg.vdist == '0) ? 31'd1 : 31'(cfg.vdist);
		end
		if (state_q == P_RAD_W && div_done) begin
			rad_q <= (div_quot > csvg_pkg::DIV_W'(csvg_pkg::RAD_MAX))
				? csvg_pkg::RAD_MAX : div_quot[30:0];
		end
		if (state_q == P_TURN_W && div_done) begin
			turn_q <= div_quot[31:0];
			mr_q   <= div_quot;
			mk_q   <= csvg_pkg::INV4PI_Q32;
			acc_q  <= '0;
		end
		// shift-add by the 1/(4 pi) constant, keeping product bits 47:16
		if (state_q == P_MUL) begin
			if (mk_q == '0) begin
				turn_q <= acc_q[47:16];
			end else begin
				acc_q <= acc_q + (mk_q[0] ? mr_q : '0);
				mr_q  <= mr_q << 1;
				mk_q  <= mk_q >> 1;
			end
		end
		if (state_q == P_TEX_W && div_done) begin
			tex_q <= div_quot[16:0];
		end
	end

	always_comb begin
		tab_wr.en        = (state_q == P_WRITE);
		tab_wr.addr      = i_q;
		tab_wr.data.turn = neg ? (32'd0 - turn_q) : turn_q;
		tab_wr.data.tex  = tex_q;
	end

	assign busy = (state_q != P_IDLE);
	assign rad  = rad_q;

endmodule

// ----- hw/rtl/csvg_cordic.sv -----
// pipelined rotation cordic, two micro-rotations per stage plus a fold stage
// depends on csvg_pkg
module csvg_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [31:0]         turn,
	input  csvg_pkg::side_t     in_side,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  cos_out,
	output logic signed [31:0]  sin_out,
	output csvg_pkg::side_t     out_side
);

	localparam int CW = csvg_pkg::CORDIC_W;
	localparam int ST = csvg_pkg::CORDIC_STAGES;
	localparam logic signed [CW-1:0] QTR  = CW'(64'sd1073741824);
	localparam logic signed [CW-1:0] HALF = CW'(64'sd2147483648);

	logic signed [CW-1:0] a_in;
	logic signed [CW-1:0] a_fold;
	logic                 fold;

	logic                 v_s1;
	logic                 rdy_s1;
	logic signed [CW-1:0] a_s1;
	logic                 fold_s1;
	csvg_pkg::side_t      side_s1;

	logic                 v_s    [ST];
	logic                 rdy_s  [ST];
	logic signed [CW-1:0] x_s    [ST];
	logic signed [CW-1:0] y_s    [ST];
	logic signed [CW-1:0] a_s    [ST];
	logic                 fold_s [ST];
	csvg_pkg::side_t      side_s [ST];

	logic signed [CW-1:0] x_last;
	logic signed [CW-1:0] y_last;

	// fold the angle into the right half plane
	always_comb begin
		a_in = CW'(signed'(turn));
		fold = (a_in > QTR) || (a_in < -QTR);
		if (!fold) begin
			a_fold = a_in;
		end else if (a_in > 0) begin
			a_fold = a_in - HALF;
		end else begin
			a_fold = a_in + HALF;
		end
	end

	assign rdy_s1   = !v_s1 || rdy_s[0];
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			a_s1    <= a_fold;
			fold_s1 <= fold;
			side_s1 <= in_side;
		end
	end

	for (genvar g = 0; g < ST; g++) begin : g_stage
		logic signed [CW-1:0] xi, yi, ai, xo, yo, ao;
		logic                 vi, fi, nrdy;
		csvg_pkg::side_t      si;

		if (g == 0) begin : g_first
			assign xi = CW'(signed'({1'b0, csvg_pkg::GAIN_Q30}));
			assign yi = '0;
			assign ai = a_s1;
			assign vi = v_s1;
			assign fi = fold_s1;
			assign si = side_s1;
		end else begin : g_next
			assign xi = x_s[g-1];
			assign yi = y_s[g-1];
			assign ai = a_s[g-1];
			assign vi = v_s[g-1];
			assign fi = fold_s[g-1];
			assign si = side_s[g-1];
		end

		if (g == ST - 1) begin : g_tail
			assign nrdy = out_ready;
		end else begin : g_mid
			assign nrdy = rdy_s[g+1];
		end

		always_comb begin
			logic signed [CW-1:0] xt, yt, at, nx;
			xt = xi;
			yt = yi;
			at = ai;
			nx = xi;
			for (int j = 0; j < csvg_pkg::STEPS_PER_STAGE; j++) begin
				if (g * csvg_pkg::STEPS_PER_STAGE + j < csvg_pkg::CORDIC_STEPS) begin
					if (at >= 0) begin
						nx = xt - (yt >>> (g * csvg_pkg::STEPS_PER_STAGE + j));
						yt = yt + (xt >>> (g * csvg_pkg::STEPS_PER_STAGE + j));
						at = at - CW'(csvg_pkg::atan_turn(g * csvg_pkg::STEPS_PER_STAGE + j));
					end else begin
						nx = xt + (yt >>> (g * csvg_pkg::STEPS_PER_STAGE + j));
						yt = yt - (xt >>> (g * csvg_pkg::STEPS_PER_STAGE + j));
						at = at + CW'(csvg_pkg::atan_turn(g * csvg_pkg::STEPS_PER_STAGE + j));
					end
					xt = nx;
				end
			end
			xo = xt;
			yo = yt;
			ao = at;
		end

		assign rdy_s[g] = !v_s[g] || nrdy;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (rdy_s[g]) begin
				v_s[g] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_s[g] && vi) begin
				x_s[g]    <= xo;
				y_s[g]    <= yo;
				a_s[g]    <= ao;
				fold_s[g] <= fi;
				side_s[g] <= si;
			end
		end
	end

	always_comb begin
		x_last = fold_s[ST-1] ? -x_s[ST-1] : x_s[ST-1];
		y_last = fold_s[ST-1] ? -y_s[ST-1] : y_s[ST-1];
	end

	assign out_valid = v_s[ST-1];
	assign cos_out   = x_last[31:0];
	assign sin_out   = y_last[31:0];
	assign out_side  = side_s[ST-1];

endmodule

// ----- hw/rtl/csvg_scale.sv -----
// radius scaling: multiply stage, then rounding, saturation and vertex placement
// depends on csvg_pkg
module csvg_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  cos_in,
	input  logic signed [31:0]  sin_in,
	input  csvg_pkg::side_t     in_side,
	input  logic [30:0]         rad,
	input  logic                vertical,
	input  logic [23:0]         width,
	input  logic [23:0]         height,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  first_x,
	output logic signed [31:0]  first_y,
	output logic signed [31:0]  second_x,
	output logic signed [31:0]  second_y,
	output logic signed [31:0]  depth_z,
	output csvg_pkg::side_t     out_side
);

	localparam logic signed [63:0] HALF_LSB = 64'sd536870912;

	logic signed [31:0] rad_s;
	logic signed [63:0] rad_w;
	logic               v_s1, v_s2, rdy_s1, rdy_s2;
	logic signed [63:0] pc_s1, ps_s1;
	csvg_pkg::side_t    side_s1, side_s2;
	logic signed [31:0] fx_s2, fy_s2, sx_s2, sy_s2, z_s2;
	logic signed [31:0] sv, zv, hw, hh;

	always_comb begin
		rad_s = signed'({1'b0, rad});
		rad_w = signed'({33'd0, rad});
		hw    = signed'({9'd0, width[23:1]});
		hh    = signed'({9'd0, height[23:1]});
		sv    = csvg_pkg::sat32((ps_s1 + HALF_LSB) >>> 30);
		zv    = csvg_pkg::sat32(((pc_s1 + HALF_LSB) >>> 30) - rad_w);
	end

	assign rdy_s1   = !v_s1 || rdy_s2;
	assign rdy_s2   = !v_s2 || out_ready;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			pc_s1   <= cos_in * rad_s;
			ps_s1   <= sin_in * rad_s;
			side_s1 <= in_side;
		end
		if (rdy_s2 && v_s1) begin
			side_s2 <= side_s1;
			z_s2    <= zv;
			if (vertical) begin
				fx_s2 <= -hw;
				fy_s2 <= sv;
				sx_s2 <= hw;
				sy_s2 <= sv;
			end else begin
				fx_s2 <= sv;
				fy_s2 <= hh;
				sx_s2 <= sv;
				sy_s2 <= -hh;
			end
		end
	end

	assign out_valid = v_s2;
	assign first_x   = fx_s2;
	assign first_y   = fy_s2;
	assign second_x  = sx_s2;
	assign second_y  = sy_s2;
	assign depth_z   = z_s2;
	assign out_side  = side_s2;

endmodule

// ----- hw/rtl/curved_screen_vertex_generator_core.sv -----
// top level of the curved screen vertex generator: configuration registers,
// angle table, lookup stage; depends on csvg_pkg, csvg_prep, csvg_cordic, csvg_scale
//
// usage
// - cfg channel: one beat writes one register (cfg_index 0..6, cfg_data); any
//   write starts a rebuild of the angle table, cfg_ready is low until it ends
// - in channel: one beat carries a segment index; out channel: one beat carries
//   the vertex pair, depth, texture coordinate and triangle slots of that index
// - throughput: one beat per cycle, fully pipelined, no gaps between beats, as
//   long as out_ready is high and no table rebuild runs
// - stages: table lookup, angle fold, ten cordic stages of two micro-rotations,
//   multiply, round and place
// - table rebuild: one serial divider shared for radius, angle and texture;
//   n+1 table entries, plus the radius division in fixed curvature mode
// - reset: registers take their defaults and the table is rebuilt straight
//   away; in_ready stays low until that is done
// - stall: every stage holds its beat while the stage after it is full, so a
//   stalled receiver backs the pipeline up without loss; bubbles still close up
module curved_screen_vertex_generator_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [24:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [6:0]          segment_index,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  first_x,
	output logic signed [31:0]  first_y,
	output logic signed [31:0]  second_x,
	output logic signed [31:0]  second_y,
	output logic signed [31:0]  depth_z,
	output logic [16:0]         tex_along,
	output logic [7:0]          first_slot,
	output logic [7:0]          second_slot,
	output logic                has_quad,
	output logic [7:0]          next_first_slot,
	output logic [7:0]          next_second_slot,
	output logic [8:0]          tri_offset
);

	localparam int IW = csvg_pkg::IDX_W;
	localparam int WW = csvg_pkg::WIDE_W;

	// configuration registers
	logic [23:0] width_q, height_q, vdist_q;
	logic [24:0] curv_q;
	logic        fixed_q, vertical_q;
	logic [6:0]  segs_q;
	logic        dirty_q;

	csvg_pkg::cfg_t    cfg;
	logic [IW-1:0]     n_eff;
	logic              prep_busy;
	logic              prep_start;
	logic [30:0]       rad;
	csvg_pkg::tab_wr_t tab_wr;

	// angle table
	csvg_pkg::tab_t    tab_mem [csvg_pkg::TAB_DEPTH];

	// lookup stage
	logic              v_s1, rdy_s1, in_acc;
	csvg_pkg::tab_t    rd_s1;
	csvg_pkg::side_t   side_s1;
	csvg_pkg::side_t   cside;
	logic [IW-1:0]     i_cl;
	logic [WW-1:0]     i_w, n_w;
	logic              quad;

	logic              cor_in_ready, cor_valid, sc_ready;
	logic signed [31:0] cos_v, sin_v;
	csvg_pkg::side_t   cor_side, out_side;

	// segment count clamped to 1..max
	always_comb begin
		if (segs_q == '0) begin
			n_eff = IW'(1);
		end else if (WW'(segs_q) > WW'(csvg_pkg::MAX_SEGMENTS)) begin
			n_eff = IW'(csvg_pkg::MAX_SEGMENTS);
		end else begin
			n_eff = IW'(segs_q);
		end
		cfg.width    = width_q;
		cfg.height   = height_q;
		cfg.vdist    = vdist_q;
		cfg.curv     = curv_q;
		cfg.fixed    = fixed_q;
		cfg.vertical = vertical_q;
		cfg.nseg     = n_eff;
	end

	assign cfg_ready  = !prep_busy && !dirty_q;
	assign prep_start = dirty_q && !prep_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= 24'd1048576;
			height_q   <= 24'd589824;
			vdist_q    <= 24'd3276800;
			curv_q     <= 25'd2949120;
			fixed_q    <= 1'b0;
			vertical_q <= 1'b0;
			segs_q     <= 7'd32;
			dirty_q    <= 1'b1;
		end else begin
			if (prep_start) dirty_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				dirty_q <= 1'b1;
				unique case (cfg_index)
					csvg_pkg::REG_WIDTH:    width_q    <= cfg_data[23:0];
					csvg_pkg::REG_HEIGHT:   height_q   <= cfg_data[23:0];
					csvg_pkg::REG_DISTANCE: vdist_q    <= cfg_data[23:0];
					csvg_pkg::REG_CURV:     curv_q     <= cfg_data;
					csvg_pkg::REG_FIXED:    fixed_q    <= cfg_data[0];
					csvg_pkg::REG_VERTICAL: vertical_q <= cfg_data[0];
					csvg_pkg::REG_SEGMENTS: segs_q     <= cfg_data[6:0];
					default: ;
				endcase
			end
		end
	end

	csvg_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (prep_start),
		.cfg    (cfg),
		.busy   (prep_busy),
		.rad    (rad),
		.tab_wr (tab_wr)
	);

	// items are only taken once the table matches the registers
	assign rdy_s1   = !v_s1 || cor_in_ready;
	assign in_ready = rdy_s1 && !prep_busy && !dirty_q;
	assign in_acc   = in_valid && in_ready;

	// index above the count is treated as the last pair
	always_comb begin
		i_w  = WW'(segment_index);
		n_w  = WW'(n_eff);
		i_cl = (i_w > n_w) ? n_eff : IW'(segment_index);
		quad = WW'(i_cl) < n_w;
	end

	always_ff @(posedge clk) begin
		if (tab_wr.en) begin
			tab_mem[tab_wr.addr] <= tab_wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_s1               <= tab_mem[i_cl];
			side_s1.tex         <= '0;
			side_s1.first_slot  <= 8'(i_cl);
			side_s1.second_slot <= 8'(WW'(i_cl) + n_w + WW'(1));
			side_s1.has_quad    <= quad;
			side_s1.next_first  <= quad ? 8'(WW'(i_cl) + WW'(1)) : 8'd0;
			side_s1.next_second <= quad ? 8'(WW'(i_cl) + n_w + WW'(2)) : 8'd0;
			side_s1.tri_offset  <= 9'(WW'(6) * WW'(i_cl));
		end
	end

	always_comb begin
		cside     = side_s1;
		cside.tex = rd_s1.tex;
	end

	csvg_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (cor_in_ready),
		.turn      (rd_s1.turn),
		.in_side   (cside),
		.out_valid (cor_valid),
		.out_ready (sc_ready),
		.cos_out   (cos_v),
		.sin_out   (sin_v),
		.out_side  (cor_side)
	);

	csvg_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cor_valid),
		.in_ready  (sc_ready),
		.cos_in    (cos_v),
		.sin_in    (sin_v),
		.in_side   (cor_side),
		.rad       (rad),
		.vertical  (vertical_q),
		.width     (width_q),
		.height    (height_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.first_x   (first_x),
		.first_y   (first_y),
		.second_x  (second_x),
		.second_y  (second_y),
		.depth_z   (depth_z),
		.out_side  (out_side)
	);

	assign tex_along        = out_side.tex;
	assign first_slot       = out_side.first_slot;
	assign second_slot      = out_side.second_slot;
	assign has_quad         = out_side.has_quad;
	assign next_first_slot  = out_side.next_first;
	assign next_second_slot = out_side.next_second;
	assign tri_offset       = out_side.tri_offset;

`ifndef NO_ASSERTIONS
	// the table is never rewritten under a beat being looked up
	a_no_wr_on_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		tab_wr.en |-> !in_acc)
		else $error("angle table written during an input beat");

	// a register write holds off input until the table is rebuilt
	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> !in_ready)
		else $error("input taken straight after a register write");

	a_quad_next: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && has_quad) |-> (next_first_slot == first_slot + 8'd1))
		else $error("next slot does not follow first slot");

	a_last_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_quad) |-> (next_first_slot == 8'd0 && next_second_slot == 8'd0))
		else $error("last pair carries triangle slots");
`endif

endmodule
